// ===== hdl/dhlt_pkg.sv =====
// ----------------------------------------------------------------------------
// dhlt_pkg
// shared constants, register indexes and the cordic arctangent table
// ----------------------------------------------------------------------------
package dhlt_pkg;

  localparam int TrigBitsDefault = 16;
  localparam int TrigBitsMax     = 24;
  localparam int CfgIdxW         = 3;
  localparam int CfgDataW        = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_JOINT_KIND = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_Z_LENGTH   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_Z_ANGLE    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_X_LENGTH   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_X_ANGLE    = 3'd4;

  // q30 start value, inverse cordic gain
  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

  // arctangent of 2^-i in binary turns
  function automatic logic signed [33:0] atan_turns(input int i);
    logic signed [33:0] v;
    begin
      case (i)
        0: v = 34'sd536870912;   1: v = 34'sd316933406;
        2: v = 34'sd167458907;   3: v = 34'sd85004756;
        4: v = 34'sd42667331;    5: v = 34'sd21354465;
        6: v = 34'sd10679838;    7: v = 34'sd5340245;
        8: v = 34'sd2670163;     9: v = 34'sd1335087;
        10: v = 34'sd667544;     11: v = 34'sd333772;
        12: v = 34'sd166886;     13: v = 34'sd83443;
        14: v = 34'sd41722;      15: v = 34'sd20861;
        16: v = 34'sd10430;      17: v = 34'sd5215;
        18: v = 34'sd2608;       19: v = 34'sd1304;
        20: v = 34'sd652;        21: v = 34'sd326;
        22: v = 34'sd163;        23: v = 34'sd81;
        default: v = 34'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== hdl/dhlt_cordic.sv =====
// ----------------------------------------------------------------------------
// dhlt_cordic
// pipelined sine/cosine, one micro-rotation per stage, q1.14 results
// ----------------------------------------------------------------------------
module dhlt_cordic #(
  parameter int TRIG_BITS = dhlt_pkg::TrigBitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [31:0]        in_angle,
  output logic               out_vld,
  output logic signed [15:0] out_cos,
  output logic signed [15:0] out_sin
);
  import dhlt_pkg::*;

  localparam int N = (TRIG_BITS < TrigBitsMax) ? TRIG_BITS : TrigBitsMax;

  // stage 0 holds the reduced angle; stage k holds the result after k steps
  logic               vld_r  [0:N+1];
  logic signed [33:0] x_r    [0:N];
  logic signed [33:0] y_r    [0:N];
  logic signed [33:0] z_r    [0:N];
  logic [1:0]         quad_r [0:N];
  logic signed [15:0] c_r, s_r;

  logic [1:0]  quad_nxt;
  logic [31:0] red_nxt;

  assign quad_nxt = 2'((in_angle + 32'h2000_0000) >> 30);
  assign red_nxt  = in_angle - {quad_nxt, 30'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= in_vld;
    x_r[0]    <= CORDIC_INV_GAIN;
    y_r[0]    <= '0;
    z_r[0]    <= 34'(signed'(red_nxt));
    quad_r[0] <= quad_nxt;
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k+1] <= 1'b0;
      else        vld_r[k+1] <= vld_r[k];
      quad_r[k+1] <= quad_r[k];
      if (z_r[k] >= 0) begin
        x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
        y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
        z_r[k+1] <= z_r[k] - atan_turns(k);
      end else begin
        x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
        y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
        z_r[k+1] <= z_r[k] + atan_turns(k);
      end
    end
  end

  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [33:0] t;
    begin
      t = (v + 34'sd32768) >>> 16;
      if (t > 34'sd16384)       return 16'sd16384;
      else if (t < -34'sd16384) return -16'sd16384;
      else                      return t[15:0];
    end
  endfunction

  logic signed [15:0] c_q, s_q;
  assign c_q = to_q14(x_r[N]);
  assign s_q = to_q14(y_r[N]);

  // quadrant fold
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[N+1] <= 1'b0;
    else        vld_r[N+1] <= vld_r[N];
    case (quad_r[N])
      2'd0:    begin c_r <= c_q;  s_r <= s_q;  end
      2'd1:    begin c_r <= -s_q; s_r <= c_q;  end
      2'd2:    begin c_r <= -c_q; s_r <= -s_q; end
      default: begin c_r <= s_q;  s_r <= -c_q; end
    endcase
  end

  assign out_vld = vld_r[N+1];
  assign out_cos = c_r;
  assign out_sin = s_r;

  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (out_cos <= 16'sd16384 && out_cos >= -16'sd16384))
    else $error("cosine out of range");
  a_vld_delay: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> ##(N+1) out_vld)
    else $error("cordic valid lost");
  a_quad_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[N] && quad_r[N] == 2'd2) |=> (out_cos == -$past(c_q)))
    else $error("quadrant fold wrong");
endmodule

// ===== hdl/dh_link_transform.sv =====
// ----------------------------------------------------------------------------
// dh_link_transform
// denavit-hartenberg link transform: rotation q1.14 and translation q16.16
// ----------------------------------------------------------------------------
// path: an accepted word passes stage a, both cordic pipes (one micro-rotation per
// register stage), stage m and the output register to out_valid
// throughput: one word per cycle; busy is never raised
// reset: synchronous active-low rst_n clears valids and config registers
// the receiver cannot stall; out_valid pulses one cycle per word
module dh_link_transform #(
  parameter int TRIG_BITS = dhlt_pkg::TrigBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dhlt_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [dhlt_pkg::CfgDataW-1:0] cfg_data,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [31:0]           in_joint_value,
  output logic                         out_valid,
  output logic signed [15:0]           out_m00,
  output logic signed [15:0]           out_m01,
  output logic signed [15:0]           out_m02,
  output logic signed [15:0]           out_m10,
  output logic signed [15:0]           out_m11,
  output logic signed [15:0]           out_m12,
  output logic signed [15:0]           out_m20,
  output logic signed [15:0]           out_m21,
  output logic signed [15:0]           out_m22,
  output logic signed [31:0]           out_tx,
  output logic signed [31:0]           out_ty,
  output logic signed [31:0]           out_tz
);
  import dhlt_pkg::*;

  localparam int N   = (TRIG_BITS < TrigBitsMax) ? TRIG_BITS : TrigBitsMax;
  localparam int LAT = N + 2; // register depth of each cordic pipe

  // configuration registers
  logic               joint_kind_r;
  logic signed [31:0] z_length_r, x_length_r;
  logic [31:0]        z_angle_r, x_angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joint_kind_r <= 1'b0;
      z_length_r   <= '0;
      z_angle_r    <= '0;
      x_length_r   <= '0;
      x_angle_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_JOINT_KIND: joint_kind_r <= cfg_data[0];
        REG_Z_LENGTH:   z_length_r   <= cfg_data;
        REG_Z_ANGLE:    z_angle_r    <= cfg_data;
        REG_X_LENGTH:   x_length_r   <= cfg_data;
        REG_X_ANGLE:    x_angle_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage a: angle and z sum
  logic               in_acc;
  logic               a_vld_r;
  logic [31:0]        theta_r;
  logic signed [31:0] zsum_r;
  logic [31:0]        theta_nxt;
  logic signed [32:0] zwide;
  logic signed [31:0] zsum_nxt;

  assign in_acc    = start && !busy;
  assign theta_nxt = joint_kind_r ? z_angle_r : z_angle_r + in_joint_value;
  assign zwide     = joint_kind_r ? 33'(z_length_r) + 33'(in_joint_value)
                                  : 33'(z_length_r);
  // saturate z sum to 32 bits
  assign zsum_nxt  = (zwide > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                     (zwide < -33'sh0_8000_0000) ? 32'sh8000_0000 : zwide[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else        a_vld_r <= in_acc;
    theta_r <= theta_nxt;
    zsum_r  <= zsum_nxt;
  end

  // two cordic pipes: joint angle and twist
  logic               t_vld, w_vld;
  logic signed [15:0] c_s, s_s, ca_s, sa_s;

  dhlt_cordic #(.TRIG_BITS(TRIG_BITS)) u_theta (
    .clk(clk), .rst_n(rst_n), .in_vld(a_vld_r), .in_angle(theta_r),
    .out_vld(t_vld), .out_cos(c_s), .out_sin(s_s)
  );
  dhlt_cordic #(.TRIG_BITS(TRIG_BITS)) u_twist (
    .clk(clk), .rst_n(rst_n), .in_vld(a_vld_r), .in_angle(x_angle_r),
    .out_vld(w_vld), .out_cos(ca_s), .out_sin(sa_s)
  );

  // delay line for z sum alongside the cordic
  logic signed [31:0] zd_r [0:LAT-1];
  always_ff @(posedge clk) begin
    zd_r[0] <= zsum_r;
    for (int k = 1; k < LAT; k++) zd_r[k] <= zd_r[k-1];
  end

  // stage m: products, registered
  logic               m_vld_r;
  logic signed [31:0] p01_r, p02_r, p11_r, p12_r;
  logic signed [47:0] ptx_r, pty_r;
  logic signed [15:0] c_m_r, s_m_r, ca_m_r, sa_m_r;
  logic signed [31:0] z_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else        m_vld_r <= t_vld;
    p01_r  <= 32'(-(32'(s_s))) * 32'(ca_s);
    p02_r  <= 32'(s_s) * 32'(sa_s);
    p11_r  <= 32'(c_s) * 32'(ca_s);
    p12_r  <= 32'(-(32'(c_s))) * 32'(sa_s);
    ptx_r  <= 48'(x_length_r) * 48'(c_s);
    pty_r  <= 48'(x_length_r) * 48'(s_s);
    c_m_r  <= c_s;
    s_m_r  <= s_s;
    ca_m_r <= ca_s;
    sa_m_r <= sa_s;
    z_m_r  <= zd_r[LAT-1];
  end

  function automatic logic signed [15:0] rnd14(input logic signed [31:0] p);
    logic signed [31:0] t;
    begin
      t = (p + 32'sd8192) >>> 14;
      return t[15:0];
    end
  endfunction

  function automatic logic signed [31:0] rnd_sat(input logic signed [47:0] p);
    logic signed [47:0] t;
    begin
      t = (p + 48'sd8192) >>> 14;
      if (t > 48'sh0000_7FFF_FFFF)       return 32'sh7FFF_FFFF;
      else if (t < -48'sh0000_8000_0000) return 32'sh8000_0000;
      else                               return t[31:0];
    end
  endfunction

  // output register
  logic               o_vld_r;
  logic signed [15:0] m00_r, m01_r, m02_r, m10_r, m11_r, m12_r, m21_r, m22_r;
  logic signed [31:0] tx_r, ty_r, tz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else        o_vld_r <= m_vld_r;
    m00_r <= c_m_r;
    m01_r <= rnd14(p01_r);
    m02_r <= rnd14(p02_r);
    m10_r <= s_m_r;
    m11_r <= rnd14(p11_r);
    m12_r <= rnd14(p12_r);
    m21_r <= sa_m_r;
    m22_r <= ca_m_r;
    tx_r  <= rnd_sat(ptx_r);
    ty_r  <= rnd_sat(pty_r);
    tz_r  <= z_m_r;
  end

  assign out_valid = o_vld_r;
  assign out_m00 = m00_r;
  assign out_m01 = m01_r;
  assign out_m02 = m02_r;
  assign out_m10 = m10_r;
  assign out_m11 = m11_r;
  assign out_m12 = m12_r;
  assign out_m20 = '0;
  assign out_m21 = m21_r;
  assign out_m22 = m22_r;
  assign out_tx  = tx_r;
  assign out_ty  = ty_r;
  assign out_tz  = tz_r;

  a_pipes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    t_vld == w_vld) else $error("cordic pipes out of step");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##(LAT+3) out_valid) else $error("word lost in pipeline");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(m_vld_r)) else $error("word invented");
endmodule
